/* src/rebq_pkg.sv */
package rebq_pkg;

    // Width of each stability counter; the counter saturates at its all-ones value.
    localparam int COUNTER_BITS = 8;

    // Width of the hold registers and of the configuration data.
    localparam int HOLD_W = 8;

    // Width used to compare a counter against a hold register.
    localparam int CMP_W = (COUNTER_BITS > HOLD_W) ? COUNTER_BITS : HOLD_W;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_HOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HOLD = 2'd1;

    // Reset values of the hold registers.
    localparam logic [HOLD_W-1:0] PRESS_HOLD_RESET = 8'd50;
    localparam logic [HOLD_W-1:0] CLOCK_HOLD_RESET = 8'd1;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_UP    = 2'd2,
        EV_DOWN  = 2'd3
    } event_code_t;

    // Outcome of one qualifier for the current tick.
    typedef struct packed {
        logic taken;   // the level was newly accepted on this tick
        logic level;   // the sampled level of this tick
    } qual_status_t;

endpackage

/* src/rotary_encoder_button_qualifier_top.sv */
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tdata: press_level, clock_level, data_level, 5 zero bits
// m_axis    out        tdata: event_code[1:0], 6 zero bits
// cfg       in         write: index 0 press_hold_ticks, 1 clock_hold_ticks
//
// Each input beat yields exactly one output beat via the input and result registers.
// One beat is accepted every cycle unless the output stalls; the rate is set by the
// input register feeding the qualifier logic and the output register behind it.
// A stalled output holds the result register; the input register then holds too,
// and s_axis_tready drops only when both are full.
// Reset clears the qualifier state and loads the hold registers with 50 and 1.
module rotary_encoder_button_qualifier_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rebq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // press, clock, data
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rebq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // event_code[1:0]
    input  logic                                 cfg_we,
    input  logic [rebq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rebq_pkg::HOLD_W-1:0]          cfg_wdata
);
    import rebq_pkg::*;

    logic [HOLD_W-1:0] press_hold_reg;
    logic [HOLD_W-1:0] clock_hold_reg;

    logic              in_valid_reg;
    logic              press_reg;
    logic              clock_reg;
    logic              data_reg;

    logic              out_valid_reg;
    event_code_t       out_code_reg;

    logic              advance;
    logic              step;
    qual_status_t      press_status;
    qual_status_t      clock_status;
    event_code_t       event_code;

    // Hold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_hold_reg <= PRESS_HOLD_RESET;
            clock_hold_reg <= CLOCK_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PRESS_HOLD)
            begin
                press_hold_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_CLOCK_HOLD)
            begin
                clock_hold_reg <= cfg_wdata;
            end
        end
    end

    // Handshake: the input register moves on whenever the result register can take it.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            press_reg <= s_axis_tdata[0];
            clock_reg <= s_axis_tdata[1];
            data_reg  <= s_axis_tdata[2];
        end
    end

    rebq_qualifier u_press (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (step),
        .level  (press_reg),
        .hold   (press_hold_reg),
        .status (press_status)
    );

    rebq_qualifier u_clock (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (step),
        .level  (clock_reg),
        .hold   (clock_hold_reg),
        .status (clock_status)
    );

    rebq_event_sel u_event_sel (
        .press_status (press_status),
        .clock_status (clock_status),
        .data_level   (data_reg),
        .event_code   (event_code)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_code_reg <= event_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_code_reg};

    // A held input beat stays in the input register while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input beat lost during output stall");

    // A beat that leaves the input register shows up at the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("processed beat not presented at output");

    // An accepted falling clock always reports a step event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && clock_status.taken && !clock_status.level) |=>
        (m_axis_tdata[1:0] == EV_UP || m_axis_tdata[1:0] == EV_DOWN))
        else $error("encoder step not reported");

    // A press event requires that the switch qualifier took a high level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && event_code == EV_PRESS) |-> (press_status.taken && press_status.level))
        else $error("press event without accepted switch level");

endmodule

/* src/rebq_qualifier.sv */
module rebq_qualifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        level,
    input  logic [rebq_pkg::HOLD_W-1:0] hold,
    output rebq_pkg::qual_status_t      status
);
    import rebq_pkg::*;

    localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

    logic                    prev_reg;
    logic                    prev_next;
    logic                    acc_reg;
    logic                    acc_next;
    logic [COUNTER_BITS-1:0] cnt_reg;
    logic [COUNTER_BITS-1:0] cnt_next;
    logic                    taken;

    // Stability count: clear on a change, otherwise count up to saturation.
    always_comb
    begin
        if (level != prev_reg)
        begin
            cnt_next = '0;
        end
        else if (cnt_reg != COUNT_MAX)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // A level that has outlasted the hold time and differs from the accepted one is taken.
    assign taken     = (CMP_W'(cnt_next) > CMP_W'(hold)) && (level != acc_reg);
    assign acc_next  = taken ? level : acc_reg;
    assign prev_next = level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            acc_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (enable)
        begin
            prev_reg <= prev_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status.taken = taken;
    assign status.level = level;

endmodule

/* src/rebq_event_sel.sv */
module rebq_event_sel (
    input  rebq_pkg::qual_status_t press_status,
    input  rebq_pkg::qual_status_t clock_status,
    input  logic                   data_level,
    output rebq_pkg::event_code_t  event_code
);
    import rebq_pkg::*;

    // An accepted falling clock outranks an accepted switch press.
    always_comb
    begin
        priority if (clock_status.taken && !clock_status.level)
        begin
            event_code = data_level ? EV_UP : EV_DOWN;
        end
        else if (press_status.taken && press_status.level)
        begin
            event_code = EV_PRESS;
        end
        else
        begin
            event_code = EV_NONE;
        end
    end

endmodule

/* sim/rotary_encoder_button_qualifier_top_tb.sv */
`timescale 1ns / 1ps

module rotary_encoder_button_qualifier_top_tb;

    import rebq_pkg::*;

    // Stability line indexes for the qualifier state arrays.
    localparam int LINE_PRESS = 0;
    localparam int LINE_CLOCK = 1;

    // Register indexes past the last real register; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Length of the forced receiver stall, in cycles.
    localparam int HOLD_OFF_CYCLES = 60;

    // Length of the run that pushes a stability counter into saturation.
    localparam int SATURATE_TICKS = 270;

    // One sampled tick, packed with the switch level in the lowest bit.
    typedef struct packed {
        logic data;
        logic clock;
        logic press;
    } tick_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;   // press, clock, data, zero fill
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;        // event_code[1:0], zero fill
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [HOLD_W-1:0]          cfg_wdata = '0;

    // Ticks waiting to be offered, and events waiting to come out.
    tick_t                      pending_ticks[$];
    event_code_t                expected_events[$];
    event_code_t                oldest_event;

    // Predictor state: hold registers and the two stability qualifiers.
    logic [HOLD_W-1:0]          press_hold_copy = PRESS_HOLD_RESET;
    logic [HOLD_W-1:0]          clock_hold_copy = CLOCK_HOLD_RESET;
    logic                       line_prev[2] = '{1'b0, 1'b0};
    logic                       line_accepted[2] = '{1'b0, 1'b0};
    logic [COUNTER_BITS-1:0]    line_count[2] = '{'0, '0};

    // Traffic shaping.
    int                         sender_idle_pct = 0;
    int                         receiver_stall_pct = 0;
    logic                       receiver_hold = 1'b0;
    logic                       in_taken = 1'b0;
    event                       hold_off_start;

    // Levels carried from one random tick to the next.
    logic                       gen_press = 1'b0;
    logic                       gen_clock = 1'b0;
    logic                       gen_data = 1'b0;

    int                         mismatch_count = 0;

    rotary_encoder_button_qualifier_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance one stability counter; returns 1 when the level is newly accepted.
    function automatic logic settle_line(input int line, input logic level,
                                         input logic [HOLD_W-1:0] hold);
        logic               taken;
        logic [CMP_W-1:0]   count_w;
        logic [CMP_W-1:0]   hold_w;
        taken = 1'b0;
        if (level != line_prev[line])
        begin
            line_count[line] = '0;
        end
        else if (line_count[line] != '1)
        begin
            line_count[line] = line_count[line] + 1'b1;
        end
        count_w = CMP_W'(line_count[line]);
        hold_w  = CMP_W'(hold);
        if (count_w > hold_w && level != line_accepted[line])
        begin
            line_accepted[line] = level;
            taken = 1'b1;
        end
        line_prev[line] = level;
        return taken;
    endfunction

    // Event for one tick; a step on the same tick as a press takes priority.
    function automatic event_code_t qualify_tick(input tick_t t);
        event_code_t code;
        logic        taken;
        code = EV_NONE;
        taken = settle_line(LINE_PRESS, t.press, press_hold_copy);
        if (taken && t.press)
        begin
            code = EV_PRESS;
        end
        taken = settle_line(LINE_CLOCK, t.clock, clock_hold_copy);
        if (taken && !t.clock)
        begin
            code = t.data ? EV_UP : EV_DOWN;
        end
        return code;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Input side: offer the next tick once the current beat has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_axis_tdata  <= {{(IN_TDATA_W - 3){1'b0}}, pending_ticks.pop_front()};
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure, plus the forced hold-off.
    always @(negedge clk)
    begin
        m_axis_tready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
    end

    // Long receiver stall, counted here so the sender keeps offering meanwhile.
    always
    begin
        @(hold_off_start);
        receiver_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        receiver_hold = 1'b0;
    end

    // Check results against the oldest expectation, then predict for new beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected event beat %0d",
                                              m_axis_tdata[1:0]));
                end
                else
                begin
                    oldest_event = expected_events.pop_front();
                    if (m_axis_tdata[1:0] != oldest_event)
                    begin
                        report_mismatch($sformatf("event_code %0d, expected %s",
                                                  m_axis_tdata[1:0], oldest_event.name()));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_events.push_back(qualify_tick(tick_t'(s_axis_tdata[2:0])));
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // Wait until every tick is sent and every event has come out.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [HOLD_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_PRESS_HOLD: press_hold_copy = value;
            CFG_CLOCK_HOLD: clock_hold_copy = value;
            default: ;
        endcase
    endtask

    task automatic set_holds(input logic [HOLD_W-1:0] press_hold,
                             input logic [HOLD_W-1:0] clock_hold);
        write_reg(CFG_PRESS_HOLD, press_hold);
        write_reg(CFG_CLOCK_HOLD, clock_hold);
    endtask

    task automatic add_ticks(input logic press, input logic clock, input logic data,
                             input int count);
        tick_t t;
        t.press = press;
        t.clock = clock;
        t.data  = data;
        repeat (count) pending_ticks.push_back(t);
    endtask

    // Bouncy switch and encoder activity: runs near the hold lengths, some noise.
    task automatic add_random_ticks(input int count);
        int    press_span;
        int    clock_span;
        tick_t t;
        press_span = (press_hold_copy > 20) ? 22 : press_hold_copy + 2;
        clock_span = (clock_hold_copy > 20) ? 22 : clock_hold_copy + 2;
        repeat (count)
        begin
            if ($urandom_range(99) < 12)
            begin
                t = tick_t'(3'($urandom_range(7)));
            end
            else
            begin
                if ($urandom_range(press_span) == 0)
                begin
                    gen_press = !gen_press;
                end
                if ($urandom_range(clock_span) == 0)
                begin
                    gen_clock = !gen_clock;
                end
                if ($urandom_range(2) == 0)
                begin
                    gen_data = !gen_data;
                end
                t.press = gen_press;
                t.clock = gen_clock;
                t.data  = gen_data;
            end
            pending_ticks.push_back(t);
        end
    endtask

    task automatic set_traffic(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Test sequence.
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset hold values, steady traffic.
        set_traffic(0, 0);
        add_random_ticks(30);
        wait_drained();

        // Directed: shortest holds, every event and the priority rule.
        set_holds(8'd0, 8'd0);
        write_reg(CFG_SPARE_LO, HOLD_W'($urandom_range(255)));
        write_reg(CFG_SPARE_HI, HOLD_W'($urandom_range(255)));
        add_ticks(1'b1, 1'b0, 1'b0, 2);   // press accepted
        add_ticks(1'b1, 1'b1, 1'b0, 2);   // clock rise, no event
        add_ticks(1'b1, 1'b0, 1'b1, 2);   // step up
        add_ticks(1'b1, 1'b1, 1'b1, 2);
        add_ticks(1'b1, 1'b0, 1'b0, 2);   // step down
        add_ticks(1'b0, 1'b1, 1'b0, 2);   // release and rise together, no event
        add_ticks(1'b1, 1'b0, 1'b1, 2);   // press and step together: step wins
        add_ticks(1'b0, 1'b1, 1'b1, 1);   // single-tick glitches are rejected
        add_ticks(1'b1, 1'b0, 1'b0, 1);
        add_ticks(1'b0, 1'b1, 1'b0, 1);
        add_ticks(1'b0, 1'b1, 1'b0, 3);
        wait_drained();

        set_holds(8'd3, 8'd2);
        set_traffic(62, 0);
        add_random_ticks(30);
        wait_drained();

        set_holds(8'd10, 8'd0);
        set_traffic(0, 62);
        add_random_ticks(30);
        wait_drained();

        // Receiver holds off while the sender keeps pushing.
        set_holds(8'd1, 8'd1);
        set_traffic(0, 0);
        -> hold_off_start;
        add_random_ticks(30);
        wait_drained();

        set_holds(8'd0, 8'd5);
        set_traffic(36, 36);
        add_random_ticks(30);
        wait_drained();

        set_holds(8'd6, 8'd3);
        set_traffic(0, 62);
        add_random_ticks(30);
        wait_drained();

        set_holds(8'd2, 8'd0);
        set_traffic(0, 0);
        add_random_ticks(30);
        wait_drained();

        // Saturated counters: 254 is reachable, 255 never is.
        set_holds(8'd0, 8'd0);
        add_ticks(1'b0, 1'b1, 1'b0, 3);
        wait_drained();
        set_holds(8'd254, 8'd255);
        set_traffic(36, 36);
        repeat (SATURATE_TICKS) add_ticks(1'b1, 1'b0, 1'($urandom_range(1)), 1);
        wait_drained();

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
        begin
            $display("rotary_encoder_button_qualifier_top_tb: PASS");
        end
        else
        begin
            $display("rotary_encoder_button_qualifier_top_tb: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(5_000_000);
        $display("ERROR: run did not complete in time");
        $display("rotary_encoder_button_qualifier_top_tb: FAIL");
        $finish;
    end

endmodule
